// File: rtl/wheel_slip_hysteresis_detector_core_macros.svh
// assertion macros used by the wheel slip detector datapath
`ifndef WHEEL_SLIP_HYSTERESIS_DETECTOR_CORE_MACROS_SVH
`define WHEEL_SLIP_HYSTERESIS_DETECTOR_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WSHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wshd assertion failed");

// consequent must hold in the cycle after the antecedent
`define WSHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wshd assertion failed");

`endif

// File: rtl/wshd_pkg.sv
// shared constants, register indexes and control structs of the wheel slip detector
package wshd_pkg;

    localparam int RATE_BITS  = 16;
    localparam int TIME_BITS  = 24;
    localparam int THR_W      = 16;
    localparam int DT_W       = 16;
    localparam int SCORE_W    = 16;
    localparam int Q_W        = 16;
    localparam int DEN_W      = TIME_BITS + 1;
    localparam int PROD_W     = SCORE_W + DT_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 2 * RATE_BITS + DT_W;
    localparam int OUT_DATA_W = 24;

    localparam logic [SCORE_W-1:0] SCORE_ONE  = 16'h8000;
    localparam logic [CNT_W-1:0]   DIV1_STEPS = 5'd15;
    localparam logic [CNT_W-1:0]   DIV2_STEPS = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTER_THR  = 3'd0,
        CFG_EXIT_THR   = 3'd1,
        CFG_ENTER_HOLD = 3'd2,
        CFG_EXIT_HOLD  = 3'd3,
        CFG_TAU        = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic capture;
        logic clear_state;
        logic reject;
        logic div1_load;
        logic div_step;
        logic calc_raw;
        logic calc_mul;
        logic div2_load;
        logic update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic cfg_ok;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/wheel_slip_hysteresis_detector_core.sv
// top level of the wheel slip detector with hysteresis and hold times
//
// channel  | direction | handshake                      | payload
// ---------+-----------+--------------------------------+------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata wheel, gyro, step; tuser op
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata slipping, score; tuser accepted
// cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// from accept to the next accept, an update request runs a 15 step
// division for the raw score and a 16 step division for the filter step, which share
// one shift-subtract divider, plus capture, multiply and update cycles
// clear requests and rejected updates go from the check state straight to the done state
// one request is in flight at a time; a finished result waits in the output
// register, and a new request is taken while it waits
// synchronous active-low reset clears config, score, flag and timers
// config is always ready; the user must write it only while the block is idle, not enforced
module wheel_slip_hysteresis_detector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side: tdata = wheel_rate[15:0], gyro_rate[31:16], time_step[47:32]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wshd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser = opcode[0]
    input  logic                              s_axis_tuser,
    // master side: tdata = slipping[0], filt_score[16:1], zero fill [23:17]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wshd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser = accepted[0]
    output logic                              m_axis_tuser,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wshd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wshd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wshd_pkg::t_cmd    w_cmd;
    wshd_pkg::t_status w_status;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    wshd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wshd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

// File: rtl/wshd_div.sv
// shared restoring shift-subtract divider, one quotient bit per cycle while i_step is high
module wshd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [wshd_pkg::DEN_W-1:0]    i_divisor,
    input  logic [wshd_pkg::DEN_W-1:0]    i_rem,
    input  logic [wshd_pkg::Q_W-1:0]      i_bits,
    input  logic [wshd_pkg::CNT_W-1:0]    i_steps,
    output logic [wshd_pkg::Q_W-1:0]      o_quot,
    output logic                          o_last
);

    logic [wshd_pkg::DEN_W-1:0] r_rem;
    logic [wshd_pkg::DEN_W-1:0] r_div;
    logic [wshd_pkg::Q_W-1:0]   r_bits;
    logic [wshd_pkg::Q_W-1:0]   r_quot;
    logic [wshd_pkg::CNT_W-1:0] r_cnt;

    logic [wshd_pkg::DEN_W:0]   w_trial;
    logic [wshd_pkg::DEN_W:0]   w_diff;
    logic                       w_ge;

    // partial remainder with the next dividend bit shifted in
    assign w_trial = {r_rem, r_bits[wshd_pkg::Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_steps;
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_rem;
            r_div  <= i_divisor;
            r_bits <= i_bits;
            r_quot <= '0;
        end else if (i_step) begin
            r_rem  <= w_ge ? w_diff[wshd_pkg::DEN_W-1:0] : w_trial[wshd_pkg::DEN_W-1:0];
            r_bits <= {r_bits[wshd_pkg::Q_W-2:0], 1'b0};
            r_quot <= {r_quot[wshd_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_last = (r_cnt == wshd_pkg::CNT_W'(1));

endmodule

// File: rtl/wshd_datapath.sv
// datapath: config registers, score filter, hold timers, slip flag and output register
`include "wheel_slip_hysteresis_detector_core_macros.svh"

module wshd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wshd_pkg::t_cmd                    i_cmd,
    output wshd_pkg::t_status                 o_status,
    input  logic [wshd_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_in_user,
    input  logic                              i_cfg_valid,
    input  logic [wshd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wshd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [wshd_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_user
);

    // configuration
    logic [wshd_pkg::THR_W-1:0]     r_enter_thr;
    logic [wshd_pkg::THR_W-1:0]     r_exit_thr;
    logic [wshd_pkg::TIME_BITS-1:0] r_enter_hold;
    logic [wshd_pkg::TIME_BITS-1:0] r_exit_hold;
    logic [wshd_pkg::TIME_BITS-1:0] r_tau;

    // state
    logic [wshd_pkg::SCORE_W-1:0]   r_score;
    logic                           r_slip;
    logic [wshd_pkg::TIME_BITS-1:0] r_enter_t;
    logic [wshd_pkg::TIME_BITS-1:0] r_exit_t;

    // captured request and intermediates
    logic                           r_opcode;
    logic [wshd_pkg::RATE_BITS-1:0] r_err;
    logic [wshd_pkg::DT_W-1:0]      r_dt;
    logic [wshd_pkg::SCORE_W-1:0]   r_mag;
    logic                           r_up;
    logic [wshd_pkg::PROD_W-1:0]    r_prod;
    logic [wshd_pkg::DEN_W-1:0]     r_den;
    logic                           r_acc;

    // output register
    logic                            r_out_valid;
    logic [wshd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_user;

    logic signed [wshd_pkg::RATE_BITS:0] w_diff;
    logic [wshd_pkg::RATE_BITS-1:0]      w_err;
    logic [wshd_pkg::SCORE_W-1:0]        w_raw;
    logic [wshd_pkg::NUM_W-1:0]          w_sum;
    logic [wshd_pkg::Q_W-1:0]            w_quot;
    logic                                w_div_last;
    logic [wshd_pkg::SCORE_W-1:0]        w_m;
    logic [wshd_pkg::TIME_BITS:0]        w_ent_sum;
    logic [wshd_pkg::TIME_BITS:0]        w_ext_sum;
    logic [wshd_pkg::TIME_BITS-1:0]      w_ent_sat;
    logic [wshd_pkg::TIME_BITS-1:0]      w_ext_sat;
    logic                                n_slip;
    logic [wshd_pkg::TIME_BITS-1:0]      n_enter_t;
    logic [wshd_pkg::TIME_BITS-1:0]      n_exit_t;

    // absolute rate difference, sign extended by one bit
    assign w_diff =
        $signed({i_in_data[wshd_pkg::RATE_BITS-1], i_in_data[wshd_pkg::RATE_BITS-1:0]})
      - $signed({i_in_data[2*wshd_pkg::RATE_BITS-1],
                 i_in_data[2*wshd_pkg::RATE_BITS-1:wshd_pkg::RATE_BITS]});
    assign w_err = w_diff[wshd_pkg::RATE_BITS]
                 ? wshd_pkg::RATE_BITS'(-w_diff)
                 : w_diff[wshd_pkg::RATE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_thr  <= '0;
            r_exit_thr   <= '0;
            r_enter_hold <= '0;
            r_exit_hold  <= '0;
            r_tau        <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wshd_pkg::CFG_ENTER_THR:  r_enter_thr  <= i_cfg_data[wshd_pkg::THR_W-1:0];
                wshd_pkg::CFG_EXIT_THR:   r_exit_thr   <= i_cfg_data[wshd_pkg::THR_W-1:0];
                wshd_pkg::CFG_ENTER_HOLD: r_enter_hold <= i_cfg_data[wshd_pkg::TIME_BITS-1:0];
                wshd_pkg::CFG_EXIT_HOLD:  r_exit_hold  <= i_cfg_data[wshd_pkg::TIME_BITS-1:0];
                wshd_pkg::CFG_TAU:        r_tau        <= i_cfg_data[wshd_pkg::TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // numerator of the filter step with round half up, then split for the divider
    assign w_sum = {1'b0, r_prod} + wshd_pkg::NUM_W'(r_den >> 1);

    wshd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (i_cmd.div1_load || i_cmd.div2_load),
        .i_step    (i_cmd.div_step),
        .i_divisor (i_cmd.div2_load ? r_den : wshd_pkg::DEN_W'(r_enter_thr)),
        .i_rem     (i_cmd.div2_load ? wshd_pkg::DEN_W'(w_sum[wshd_pkg::NUM_W-1:wshd_pkg::Q_W])
                                    : wshd_pkg::DEN_W'(r_err)),
        .i_bits    (i_cmd.div2_load ? w_sum[wshd_pkg::Q_W-1:0] : '0),
        .i_steps   (i_cmd.div2_load ? wshd_pkg::DIV2_STEPS : wshd_pkg::DIV1_STEPS),
        .o_quot    (w_quot),
        .o_last    (w_div_last)
    );

    // raw score saturates at one once the error reaches the enter threshold
    assign w_raw = (r_err >= r_enter_thr) ? wshd_pkg::SCORE_ONE
                                          : {1'b0, w_quot[wshd_pkg::Q_W-2:0]};
    assign w_m   = (w_quot > r_mag) ? r_mag : w_quot;

    assign w_ent_sum = {1'b0, r_enter_t} + wshd_pkg::TIME_BITS'(r_dt);
    assign w_ext_sum = {1'b0, r_exit_t} + wshd_pkg::TIME_BITS'(r_dt);
    assign w_ent_sat = w_ent_sum[wshd_pkg::TIME_BITS] ? '1 : w_ent_sum[wshd_pkg::TIME_BITS-1:0];
    assign w_ext_sat = w_ext_sum[wshd_pkg::TIME_BITS] ? '1 : w_ext_sum[wshd_pkg::TIME_BITS-1:0];

    // hysteresis with hold timers
    always_comb begin
        n_slip    = r_slip;
        n_enter_t = r_enter_t;
        n_exit_t  = r_exit_t;
        if (!r_slip) begin
            n_exit_t = '0;
            if (r_err >= r_enter_thr) begin
                n_enter_t = w_ent_sat;
                if (w_ent_sat >= r_enter_hold) begin
                    n_slip    = 1'b1;
                    n_enter_t = '0;
                end
            end else begin
                n_enter_t = '0;
            end
        end else begin
            n_enter_t = '0;
            if (r_err <= r_exit_thr) begin
                n_exit_t = w_ext_sat;
                if (w_ext_sat >= r_exit_hold) begin
                    n_slip   = 1'b0;
                    n_exit_t = '0;
                end
            end else begin
                n_exit_t = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score   <= '0;
            r_slip    <= 1'b0;
            r_enter_t <= '0;
            r_exit_t  <= '0;
        end else if (i_cmd.clear_state) begin
            r_score   <= '0;
            r_slip    <= 1'b0;
            r_enter_t <= '0;
            r_exit_t  <= '0;
        end else if (i_cmd.update) begin
            r_score   <= r_up ? r_score + w_m : r_score - w_m;
            r_slip    <= n_slip;
            r_enter_t <= n_enter_t;
            r_exit_t  <= n_exit_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= i_in_user;
            r_err    <= w_err;
            r_dt     <= i_in_data[wshd_pkg::IN_DATA_W-1:2*wshd_pkg::RATE_BITS];
        end
        if (i_cmd.calc_raw) begin
            r_up  <= (w_raw >= r_score);
            r_mag <= (w_raw >= r_score) ? w_raw - r_score : r_score - w_raw;
        end
        if (i_cmd.calc_mul) begin
            r_prod <= r_mag * r_dt;
            r_den  <= wshd_pkg::DEN_W'(r_tau) + wshd_pkg::DEN_W'(r_dt);
        end
        if (i_cmd.clear_state || i_cmd.update) begin
            r_acc <= 1'b1;
        end else if (i_cmd.reject) begin
            r_acc <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= wshd_pkg::OUT_DATA_W'({r_score, r_slip});
            r_out_user <= r_acc;
        end
    end

    assign o_status.is_clear = (r_opcode == wshd_pkg::OP_CLEAR);
    assign o_status.cfg_ok   = (r_enter_thr != '0) && (r_exit_thr < r_enter_thr)
                            && (r_dt != '0);
    assign o_status.div_last = w_div_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    `WSHD_ASSERT_NOW(a_score_range, i_clk, i_rst_n, 1'b1, r_score <= wshd_pkg::SCORE_ONE)
    `WSHD_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, i_cmd.clear_state, (r_score == '0) && !r_slip && (r_enter_t == '0) && (r_exit_t == '0))
    `WSHD_ASSERT_NEXT(a_reject_holds, i_clk, i_rst_n, i_cmd.reject, $stable(r_score) && $stable(r_slip) && !r_acc)
    `WSHD_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

// File: rtl/wshd_ctrl.sv
// controller state machine sequencing capture, two divisions, multiply and update
module wshd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wshd_pkg::t_status i_status,
    output wshd_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_RAW   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_LOAD2 = 9'b000100000,
        S_DIV2  = 9'b001000000,
        S_UPD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.is_clear) begin
                    o_cmd.clear_state = 1'b1;
                    n_state           = S_DONE;
                end else if (!i_status.cfg_ok) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div1_load = 1'b1;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.calc_raw = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state        = S_LOAD2;
            end
            S_LOAD2: begin
                o_cmd.div2_load = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
